>>> rtl/core/rfq_pkg.sv
// ----------------------------------------------------------------------------
// rfq_pkg: shared types for the reversible queue
// Operation codes of the request channel, status codes of the result channel,
// and the command the control logic broadcasts to every chain storage cell.
// ----------------------------------------------------------------------------
package rfq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_REVERSE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUSH_TAIL  = 3'd1,
        CMD_SHIFT_DOWN = 3'd2,
        CMD_SHIFT_UP   = 3'd3,
        CMD_DROP_LAST  = 3'd4
    } t_cmd;

endpackage

>>> rtl/core/reversible_fifo_queue.sv
// ----------------------------------------------------------------------------
// reversible_fifo_queue: bounded queue of signed values with order reversal
// Values sit packed from cell zero upward in a chain of storage cells. In
// normal order the front is cell zero; when reversed the front is the last
// occupied cell. Reversal only toggles the direction flag.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    operation, item_value
//   result    out        o_out_valid / i_out_ready  status, removed, front,
//                                                   back, count, empty
//
// One request is taken per cycle; its result appears on the next cycle.
// The chain cells update in the cycle of acceptance, so front and back are
// read directly from the cells while the result waits.
// A new request is taken in the same cycle in which the pending result is
// taken; while a result stalls, no request is taken.
// Reset clears the occupancy bits, count and direction; stored values keep
// whatever they held.
// ----------------------------------------------------------------------------
module reversible_fifo_queue
    import rfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_operation,
    input  logic signed [DATA_W-1:0]             i_item_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic signed [DATA_W-1:0]             o_removed_value,
    output logic signed [DATA_W-1:0]             o_front_value,
    output logic signed [DATA_W-1:0]             o_back_value,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_entry_count,
    output logic                                 o_is_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] cell_data  [QUEUE_DEPTH];
    logic              cell_valid [QUEUE_DEPTH];
    logic              cell_last  [QUEUE_DEPTH];

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_reversed, n_reversed;
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_removed, n_removed;
    t_cmd              cmd;
    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic [DATA_W-1:0] last_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == FULL_CNT);

    always_comb begin
        last_data = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (cell_last[k]) begin
                last_data = last_data | cell_data[k];
            end
        end
    end

    always_comb begin
        cmd        = CMD_HOLD;
        n_count    = r_count;
        n_reversed = r_reversed;
        n_status   = ST_OK;
        n_removed  = '0;
        if (accept) begin
            case (t_op'(i_operation))
                OP_NONE: begin
                end
                OP_INSERT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        cmd     = r_reversed ? CMD_SHIFT_UP : CMD_PUSH_TAIL;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        cmd       = r_reversed ? CMD_DROP_LAST : CMD_SHIFT_DOWN;
                        n_removed = r_reversed ? last_data : cell_data[0];
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                OP_REVERSE: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_reversed = !r_reversed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] left_data;
            logic              left_valid;
            logic [DATA_W-1:0] right_data;
            logic              right_valid;

            if (g == 0) begin : g_first
                assign left_data  = i_item_value;
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_data  = cell_data[g-1];
                assign left_valid = cell_valid[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_data  = cell_data[g+1];
                assign right_valid = cell_valid[g+1];
            end

            rfq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (cmd),
                .i_value       (i_item_value),
                .i_left_data   (left_data),
                .i_left_valid  (left_valid),
                .i_right_data  (right_data),
                .i_right_valid (right_valid),
                .o_data        (cell_data[g]),
                .o_valid       (cell_valid[g]),
                .o_last        (cell_last[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_reversed  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_reversed <= n_reversed;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_front_value   = is_empty ? '0 : (r_reversed ? last_data : cell_data[0]);
    assign o_back_value    = is_empty ? '0 : (r_reversed ? cell_data[0] : last_data);
    assign o_entry_count   = r_count;
    assign o_is_empty      = is_empty;

endmodule

>>> rtl/core/rfq_cell.sv
// ----------------------------------------------------------------------------
// rfq_cell: one storage cell of the queue chain
// Holds one value and its occupancy bit. Under the broadcast command it
// keeps its value, takes its lower or upper neighbor's value, loads the
// new value when it is the first free cell, or frees itself when last.
// ----------------------------------------------------------------------------
module rfq_cell
    import rfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic              i_left_valid,
    input  logic [DATA_W-1:0] i_right_data,
    input  logic              i_right_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic              o_last
);

    logic [DATA_W-1:0] r_data, n_data;
    logic              r_valid, n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_PUSH_TAIL: begin
                if (i_left_valid && !r_valid) begin
                    n_data  = i_value;
                    n_valid = 1'b1;
                end
            end
            CMD_SHIFT_DOWN: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            CMD_SHIFT_UP: begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
            CMD_DROP_LAST: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;

endmodule

>>> rtl/core/rfq_checker.sv
// ----------------------------------------------------------------------------
// rfq_checker: port-level checks for the reversible queue
// Watches both channels: a stalled request or result holds its payload, and
// status, count and empty flag agree with one another. Bound to every
// instance of the top level.
// ----------------------------------------------------------------------------
module rfq_checker
    import rfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_ready,
    input  logic [1:0]                           i_operation,
    input  logic signed [DATA_W-1:0]             i_item_value,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic [1:0]                           o_status,
    input  logic signed [DATA_W-1:0]             o_removed_value,
    input  logic signed [DATA_W-1:0]             o_front_value,
    input  logic signed [DATA_W-1:0]             o_back_value,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_entry_count,
    input  logic                                 o_is_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    a_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_operation)
            && $stable(i_item_value))
        else $error("stalled request changed");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_front_value)
            && $stable(o_back_value) && $stable(o_entry_count))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0))
            && (!o_is_empty || (o_front_value == '0 && o_back_value == '0)))
        else $error("empty flag disagrees with count or end values");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |->
            o_entry_count == CNT_W'(QUEUE_DEPTH) && o_removed_value == '0)
        else $error("full status with queue not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_is_empty && o_removed_value == '0)
        else $error("empty status with values held");

endmodule

bind reversible_fifo_queue rfq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rfq_checker (.*);

>>> tb/sv/reversible_fifo_queue_tb.sv
// ----------------------------------------------------------------------------
// reversible_fifo_queue_tb: self-checking testbench for the reversible queue
// A ring-buffer model with a direction flag predicts the report of every
// accepted request. A checker compares each accepted report, field by field,
// with the oldest prediction. Stimulus runs a short directed sequence, fill
// and overflow rounds, a back-to-back stretch and a long weighted random mix,
// with random gaps on the request side and random stalls on the report side.
// ----------------------------------------------------------------------------
module reversible_fifo_queue_tb;
    import rfq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int MIX_ITEMS   = 750;

    typedef struct {
        t_status                   status;
        logic signed [DATA_W-1:0]  removed;
        logic signed [DATA_W-1:0]  front;
        logic signed [DATA_W-1:0]  back;
        logic [CNT_W-1:0]          count;
        logic                      empty;
    } t_queue_report;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_operation = 2'd0;
    logic signed [DATA_W-1:0]  i_item_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic signed [DATA_W-1:0]  o_removed_value;
    logic signed [DATA_W-1:0]  o_front_value;
    logic signed [DATA_W-1:0]  o_back_value;
    logic [CNT_W-1:0]          o_entry_count;
    logic                      o_is_empty;

    logic signed [DATA_W-1:0]  ring_slots [DEPTH];
    int                        ring_head = 0;
    int                        ring_tail = 0;
    int                        ring_count = 0;
    bit                        ring_reversed = 1'b0;

    t_queue_report             predicted_reports [$];
    int                        error_count = 0;
    int                        cycle_count = 0;
    bit                        gaps_on = 1'b1;
    bit                        stalls_on = 1'b1;
    int                        stall_left = 0;

    reversible_fifo_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_queue_report apply_queue_op(t_op op, logic signed [DATA_W-1:0] value);
        t_queue_report rep;
        int last;
        rep = '{ST_OK, '0, '0, '0, '0, 1'b0};
        case (op)
            OP_INSERT: begin
                if (ring_count >= DEPTH) begin
                    rep.status = ST_FULL;
                end else if (!ring_reversed) begin
                    ring_slots[ring_tail] = value;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_count++;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_slots[ring_head] = value;
                    ring_count++;
                end
            end
            OP_REMOVE: begin
                if (ring_count == 0) begin
                    rep.status = ST_EMPTY;
                end else if (!ring_reversed) begin
                    rep.removed = ring_slots[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end else begin
                    ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
                    rep.removed = ring_slots[ring_tail];
                    ring_count--;
                end
            end
            OP_REVERSE: begin
                if (ring_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    ring_reversed = !ring_reversed;
                end
            end
            default: ;
        endcase
        if (ring_count != 0) begin
            last = (ring_tail + DEPTH - 1) % DEPTH;
            rep.front = ring_reversed ? ring_slots[last] : ring_slots[ring_head];
            rep.back = ring_reversed ? ring_slots[ring_head] : ring_slots[last];
        end
        rep.count = CNT_W'(ring_count);
        rep.empty = (ring_count == 0);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!stalls_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= pick_pause();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : report_checker
        t_queue_report exp_rep;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted_reports.push_back(apply_queue_op(t_op'(i_operation), i_item_value));
            end
            if (o_out_valid && i_out_ready) begin
                if (predicted_reports.size() == 0) begin
                    $display("%0t: report with no request outstanding, status %0d",
                             $time, o_status);
                    error_count++;
                end else begin
                    exp_rep = predicted_reports.pop_front();
                    if (o_status !== exp_rep.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rep.status, o_status);
                        error_count++;
                    end
                    if (o_removed_value !== exp_rep.removed) begin
                        $display("%0t: removed value expected %0d actual %0d",
                                 $time, exp_rep.removed, o_removed_value);
                        error_count++;
                    end
                    if (o_front_value !== exp_rep.front) begin
                        $display("%0t: front value expected %0d actual %0d",
                                 $time, exp_rep.front, o_front_value);
                        error_count++;
                    end
                    if (o_back_value !== exp_rep.back) begin
                        $display("%0t: back value expected %0d actual %0d",
                                 $time, exp_rep.back, o_back_value);
                        error_count++;
                    end
                    if (o_entry_count !== exp_rep.count) begin
                        $display("%0t: entry count expected %0d actual %0d",
                                 $time, exp_rep.count, o_entry_count);
                        error_count++;
                    end
                    if (o_is_empty !== exp_rep.empty) begin
                        $display("%0t: empty flag expected %0d actual %0d",
                                 $time, exp_rep.empty, o_is_empty);
                        error_count++;
                    end
                end
            end
        end
    end

    // The request stays valid after acceptance until the next call decides
    // whether to present another request at once or to idle first.
    task automatic send_request(t_op op, logic signed [DATA_W-1:0] value);
        int gap;
        gap = gaps_on ? pick_pause() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_operation <= 2'($urandom);
            i_item_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_item_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(OP_REMOVE, 32'sd5);
        send_request(OP_REVERSE, 32'sd0);
        send_request(OP_NONE, -32'sd1);
        send_request(OP_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
        send_request(OP_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_REVERSE, 32'sd0);
        send_request(OP_NONE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REVERSE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REVERSE, 32'sd0);
        send_request(OP_INSERT, 32'sd7);
        send_request(OP_REVERSE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        wait_for_drain();
    endtask

    task automatic test_fill_and_overflow();
        repeat (3) begin
            repeat (DEPTH) send_request(OP_INSERT, pick_value());
            send_request(OP_INSERT, pick_value());
            send_request(OP_REVERSE, 32'sd0);
            send_request(OP_INSERT, pick_value());
            send_request(OP_NONE, pick_value());
            repeat ($urandom_range(3, 10)) send_request(OP_REMOVE, pick_value());
            repeat ($urandom_range(3, 10)) send_request(OP_INSERT, pick_value());
            send_request(OP_REVERSE, 32'sd0);
            repeat (DEPTH + 1) send_request(OP_REMOVE, pick_value());
            send_request(OP_REVERSE, pick_value());
        end
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        gaps_on <= 1'b0;
        stalls_on <= 1'b0;
        repeat (60) send_request(t_op'($urandom_range(0, 3)), pick_value());
        stalls_on <= 1'b1;
        repeat (20) send_request(t_op'($urandom_range(0, 3)), pick_value());
        gaps_on <= 1'b1;
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        int insert_weight;
        int r;
        t_op op;
        insert_weight = 55;
        for (int n = 0; n < MIX_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_weight = 25;
                    1: insert_weight = 45;
                    default: insert_weight = 70;
                endcase
            end
            if (n % 150 == 149) begin
                wait_for_drain();
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                op = OP_NONE;
            end else if (r < 20) begin
                op = OP_REVERSE;
            end else if (r < 20 + insert_weight) begin
                op = OP_INSERT;
            end else begin
                op = OP_REMOVE;
            end
            send_request(op, pick_value());
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_overflow();
        test_back_to_back();
        test_random_mix();
        repeat (10) @(posedge i_clk);
        if (predicted_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, predicted_reports.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
